// File: hw/rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, codes and character helpers for the integer to ascii formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic        clear_total;
    } num_word_t;

    typedef struct packed {
        logic [7:0]  character;
        logic        last_char;
        logic [31:0] running_total;
    } chr_word_t;

    localparam logic [1:0] KIND_DEC  = 2'd0;
    localparam logic [1:0] KIND_HEXL = 2'd1;
    localparam logic [1:0] KIND_HEXU = 2'd2;
    localparam logic [1:0] KIND_PTR  = 2'd3;

    localparam logic [1:0] SRC_DIGIT  = 2'd0;
    localparam logic [1:0] SRC_MINUS  = 2'd1;
    localparam logic [1:0] SRC_PREFIX = 2'd2;
    localparam logic [1:0] SRC_NIL    = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    localparam int DEC_STEPS  = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int PTR_DIGITS = 16;

    localparam logic [2:0] NIL_LAST = 3'd4;

    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       skip;
        logic       emit;
        logic [1:0] src;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       negative;
        logic       ptr_zero;
        logic       cnt_one;
        logic       top_zero;
        logic       idx_one;
        logic       idx_last;
        logic       can_emit;
    } status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UP_A : CHAR_LOW_A;
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + {4'b0, nib};
        end
        return base + {4'b0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] nil_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6c;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/i2a_ctrl.sv
// ----------------------------------------------------------------------------
// i2a_ctrl
// sequencer: conversion, leading zero skip and character emission steps
// ----------------------------------------------------------------------------
module i2a_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              num_valid,
    output logic              num_stall,
    input  i2a_pkg::status_t  status,
    output i2a_pkg::cmd_t     cmd
);
    import i2a_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_CONV     = 3'd2;
    localparam logic [2:0] ST_SIGN     = 3'd3;
    localparam logic [2:0] ST_PREFIX   = 3'd4;
    localparam logic [2:0] ST_NIL      = 3'd5;
    localparam logic [2:0] ST_SKIP     = 3'd6;
    localparam logic [2:0] ST_DIGIT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign num_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_DIGIT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.kind) inside
                    KIND_DEC:           state_next = ST_CONV;
                    KIND_HEXL, KIND_HEXU: state_next = ST_SKIP;
                    default:            state_next = status.ptr_zero ? ST_NIL : ST_PREFIX;
                endcase
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (status.cnt_one)
                begin
                    state_next = status.negative ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                cmd.src = SRC_MINUS;
                if (status.can_emit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_SKIP;
                end
            end
            ST_PREFIX:
            begin
                cmd.src = SRC_PREFIX;
                if (status.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_one)
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_NIL:
            begin
                cmd.src = SRC_NIL;
                if (status.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SKIP:
            begin
                if (status.top_zero && !status.cnt_one)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/i2a_dp.sv
// ----------------------------------------------------------------------------
// i2a_dp
// datapath: bcd shift converter, digit shifter, character total, output word
// ----------------------------------------------------------------------------
module i2a_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  i2a_pkg::num_word_t  num_word,
    input  i2a_pkg::cmd_t       cmd,
    output i2a_pkg::status_t    status,
    output logic                chr_valid,
    input  logic                chr_stall,
    output i2a_pkg::chr_word_t  chr_word
);
    import i2a_pkg::*;

    logic [63:0] digits_reg;
    logic [31:0] bin_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  idx_reg;
    logic [1:0]  kind_reg;
    logic        neg_reg;
    logic        ptr_zero_reg;
    logic [31:0] total_reg;
    logic        out_valid_reg;
    chr_word_t   out_word_reg;

    logic [31:0] low;
    logic [31:0] mag;
    logic [39:0] bcd_adj;
    logic [3:0]  top_nib;
    logic [7:0]  char_sel;
    logic        last_sel;
    logic [31:0] total_inc;

    assign low       = num_word.value[31:0];
    assign mag       = low[31] ? (~low + 32'd1) : low;
    assign top_nib   = digits_reg[63:60];
    assign total_inc = total_reg + 32'd1;

    // add three to every bcd digit of five or more
    always_comb
    begin
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (digits_reg[24 + 4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = digits_reg[24 + 4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = digits_reg[24 + 4*d +: 4];
            end
        end
    end

    always_comb
    begin
        char_sel = hex_char(top_nib, kind_reg == KIND_HEXU);
        last_sel = 1'b0;
        case (cmd.src)
            SRC_MINUS:
            begin
                char_sel = CHAR_MINUS;
            end
            SRC_PREFIX:
            begin
                char_sel = (idx_reg == 3'd0) ? CHAR_ZERO : CHAR_X;
            end
            SRC_NIL:
            begin
                char_sel = nil_char(idx_reg);
                last_sel = (idx_reg == NIL_LAST);
            end
            default:
            begin
                last_sel = (cnt_reg == 6'd1);
            end
        endcase
    end

    assign status.kind     = kind_reg;
    assign status.negative = neg_reg;
    assign status.ptr_zero = ptr_zero_reg;
    assign status.cnt_one  = (cnt_reg == 6'd1);
    assign status.top_zero = (top_nib == 4'd0);
    assign status.idx_one  = (idx_reg == 3'd1);
    assign status.idx_last = (idx_reg == NIL_LAST);
    assign status.can_emit = !out_valid_reg || !chr_stall;

    assign chr_valid = out_valid_reg;
    assign chr_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            kind_reg      <= KIND_DEC;
            neg_reg       <= 1'b0;
            ptr_zero_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_inc;
            end
            else if (!chr_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                kind_reg     <= num_word.kind;
                neg_reg      <= (num_word.kind == KIND_DEC) && low[31];
                ptr_zero_reg <= (num_word.value == 64'd0);
                idx_reg      <= '0;
                if (num_word.clear_total)
                begin
                    total_reg <= '0;
                end
                case (num_word.kind) inside
                    KIND_DEC:             cnt_reg <= 6'(DEC_STEPS);
                    KIND_HEXL, KIND_HEXU: cnt_reg <= 6'(HEX_DIGITS);
                    default:              cnt_reg <= 6'(PTR_DIGITS);
                endcase
            end
            else if (cmd.dabble)
            begin
                cnt_reg <= (cnt_reg == 6'd1) ? 6'(DEC_DIGITS) : cnt_reg - 6'd1;
            end
            else if (cmd.skip || (cmd.emit && cmd.src == SRC_DIGIT))
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case (num_word.kind) inside
                KIND_DEC:
                begin
                    digits_reg <= '0;
                    bin_reg    <= mag;
                end
                KIND_HEXL, KIND_HEXU:
                begin
                    digits_reg <= {low, 32'd0};
                end
                default:
                begin
                    digits_reg <= num_word.value;
                end
            endcase
        end
        else if (cmd.dabble)
        begin
            digits_reg <= {bcd_adj[38:0], bin_reg[31], 24'd0};
            bin_reg    <= {bin_reg[30:0], 1'b0};
        end
        else if (cmd.skip || (cmd.emit && cmd.src == SRC_DIGIT))
        begin
            digits_reg <= {digits_reg[59:0], 4'd0};
        end

        if (cmd.emit)
        begin
            out_word_reg.character     <= char_sel;
            out_word_reg.last_char     <= last_sel;
            out_word_reg.running_total <= total_inc;
        end
    end

endmodule

// File: hw/rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style signed decimal, hex and pointer text, one character per word
// ----------------------------------------------------------------------------
// One number is taken at a time and its characters leave most significant
// first, at most one per cycle, the final one flagged by last_char. Signed
// decimal runs the 32-step binary to bcd shift converter, then emits a minus
// sign when negative, then skips leading zeros and emits the digits. 32-bit
// hex and pointer text, the latter after its "0x" prefix, start at the leading
// zero skip, which drops one nibble a cycle; a zero pointer prints "(nil)".
// num_stall drops again at the clock edge that loads the final character into
// the output register.
module integer_to_ascii_formatter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  i2a_pkg::num_word_t  num_word,
    output logic                chr_valid,
    input  logic                chr_stall,
    output i2a_pkg::chr_word_t  chr_word
);
    import i2a_pkg::*;

    cmd_t    cmd;
    status_t status;

    i2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .status    (status),
        .cmd       (cmd)
    );

    i2a_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_word  (num_word),
        .cmd       (cmd),
        .status    (status),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_word  (chr_word)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && !num_stall |=> num_stall)
        else $error("formatter idle right after taking a number");

    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !num_stall |-> chr_word.last_char)
        else $error("formatter idle with an unfinished run pending");

    a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_stall |=> chr_valid && $stable(chr_word))
        else $error("character word changed while stalled");
`endif

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the integer to ascii formatter against its own text predictor
// ----------------------------------------------------------------------------
// Numbers are driven on the num channel in random bursts. Every accepted number
// is turned into its expected characters and running totals. Each character
// word that leaves the block is compared with the oldest one still waiting.
// A directed set covers the field extremes, every kind and the special values.
// It is followed by random numbers, with random stalls on the character side.
// ----------------------------------------------------------------------------
package tb_scoreboard_pkg;

    import i2a_pkg::*;

    class char_scoreboard;

        logic [31:0] emitted_total;
        chr_word_t   expected_chars[$];
        int          errors;

        function new();
            emitted_total = '0;
            errors = 0;
        endfunction

        function void note_number(num_word_t w);
            logic [7:0]  text[$];
            logic [7:0]  digits[$];
            logic [31:0] mag;
            logic [63:0] nibbles;
            string       digit_set;
            chr_word_t   c;
            if (w.clear_total)
            begin
                emitted_total = '0;
            end
            digit_set = (w.kind == KIND_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
            case (w.kind)
                KIND_DEC:
                begin
                    mag = w.value[31:0];
                    if (mag[31])
                    begin
                        text.push_back(CHAR_MINUS);
                        mag = ~mag + 32'd1;
                    end
                    do
                    begin
                        digits.push_front(8'(32'(CHAR_ZERO) + mag % 32'd10));
                        mag = mag / 32'd10;
                    end
                    while (mag != 0);
                end
                KIND_HEXL, KIND_HEXU:
                begin
                    nibbles = {32'd0, w.value[31:0]};
                    do
                    begin
                        digits.push_front(digit_set[int'(nibbles[3:0])]);
                        nibbles = nibbles >> 4;
                    end
                    while (nibbles != 0);
                end
                default:
                begin
                    if (w.value == 0)
                    begin
                        digits = '{"(", "n", "i", "l", ")"};
                    end
                    else
                    begin
                        text.push_back("0");
                        text.push_back("x");
                        nibbles = w.value;
                        do
                        begin
                            digits.push_front(digit_set[int'(nibbles[3:0])]);
                            nibbles = nibbles >> 4;
                        end
                        while (nibbles != 0);
                    end
                end
            endcase
            foreach (digits[i])
            begin
                text.push_back(digits[i]);
            end
            foreach (text[i])
            begin
                emitted_total = emitted_total + 32'd1;
                c.character = text[i];
                c.last_char = (i == text.size() - 1);
                c.running_total = emitted_total;
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(chr_word_t got);
            chr_word_t exp_c;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character word %h", got);
                errors++;
                return;
            end
            exp_c = expected_chars.pop_front();
            if (got.character !== exp_c.character)
            begin
                $error("character: expected %h, got %h", exp_c.character, got.character);
                errors++;
            end
            if (got.last_char !== exp_c.last_char)
            begin
                $error("last_char: expected %b, got %b", exp_c.last_char, got.last_char);
                errors++;
            end
            if (got.running_total !== exp_c.running_total)
            begin
                $error("running_total: expected %0d, got %0d",
                       exp_c.running_total, got.running_total);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

    endclass

endpackage

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2a_pkg::*;
    import tb_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 410;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      num_valid;
    logic      num_stall;
    num_word_t num_word;
    logic      chr_valid;
    logic      chr_stall = 1'b0;
    chr_word_t chr_word;

    char_scoreboard sb = new();
    int             cycle_count = 0;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;

    integer_to_ascii_formatter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num_word  (num_word),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_word  (chr_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (num_valid && !num_stall)
            begin
                sb.note_number(num_word);
            end
            if (chr_valid && !chr_stall)
            begin
                sb.check_char(chr_word);
            end
        end
    end

    // receiver stall pattern: off, light, heavy, periodic
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       chr_stall <= 1'b0;
            1:       chr_stall <= ($urandom_range(0, 3) == 0);
            2:       chr_stall <= ($urandom_range(0, 9) < 7);
            default: chr_stall <= stall_left[3];
        endcase
    end

    function automatic num_word_t make_number(logic [1:0] kind, logic [63:0] value,
                                              logic clear_total);
        num_word_t w;
        w.kind = kind;
        w.value = value;
        w.clear_total = clear_total;
        return w;
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = 64'($urandom_range(0, 16));
            2: v = {v[63:32], -32'($urandom_range(0, 1000))};
            3: v = {v[63:32], 32'h8000_0000 | (32'($urandom_range(0, 3)))};
            default: ;
        endcase
        return v;
    endfunction

    function automatic num_word_t random_number();
        return make_number(2'($urandom_range(0, 3)), pick_value(), $urandom_range(0, 9) == 0);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_number(input num_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                num_valid = 1'b0;
                repeat (gap)
                begin
                    num_word = random_number();
                    @(negedge clk);
                end
            end
            burst_left = $urandom_range(1, 10);
        end
        num_valid = 1'b1;
        num_word = w;
        do
        begin
            @(posedge clk);
        end
        while (num_stall);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_chars();
        num_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        num_word_t directed[$];
        rst_n = 1'b0;
        num_valid = 1'b0;
        num_word = '0;
        directed.push_back(make_number(KIND_DEC,  64'd0, 1'b0));
        directed.push_back(make_number(KIND_DEC,  64'd1, 1'b0));
        directed.push_back(make_number(KIND_DEC,  64'h0000_0000_FFFF_FFFF, 1'b0));
        directed.push_back(make_number(KIND_DEC,  64'h0000_0000_7FFF_FFFF, 1'b1));
        directed.push_back(make_number(KIND_DEC,  64'h0000_0000_8000_0000, 1'b0));
        directed.push_back(make_number(KIND_DEC,  64'hDEAD_BEEF_0000_007B, 1'b0));
        directed.push_back(make_number(KIND_DEC,  64'hFFFF_FFFF_3B9A_CA00, 1'b0));
        directed.push_back(make_number(KIND_HEXL, 64'd0, 1'b0));
        directed.push_back(make_number(KIND_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        directed.push_back(make_number(KIND_HEXL, 64'h1234_5678_ABCD_EF01, 1'b1));
        directed.push_back(make_number(KIND_HEXL, 64'h0000_0000_0000_0010, 1'b0));
        directed.push_back(make_number(KIND_HEXU, 64'd0, 1'b0));
        directed.push_back(make_number(KIND_HEXU, 64'h0000_0000_FFFF_FFFF, 1'b0));
        directed.push_back(make_number(KIND_HEXU, 64'hFFFF_FFFF_0ABC_DEF9, 1'b0));
        directed.push_back(make_number(KIND_PTR,  64'd0, 1'b0));
        directed.push_back(make_number(KIND_PTR,  64'd1, 1'b1));
        directed.push_back(make_number(KIND_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        directed.push_back(make_number(KIND_PTR,  64'h8000_0000_0000_0000, 1'b0));
        directed.push_back(make_number(KIND_PTR,  64'h0000_0001_0000_0000, 1'b0));
        directed.push_back(make_number(KIND_PTR,  64'h0000_0000_DEAD_BEEF, 1'b1));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
        begin
            send_number(directed[i]);
        end
        drain_chars();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_number(random_number());
            if (i == RANDOM_ITEMS / 2)
            begin
                drain_chars();
            end
        end
        drain_chars();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
